// File: src/ysc_pkg.sv
// shared widths and codes for the yaw spin cue detector
// no dependencies; used by the channel interfaces and the top level
package ysc_pkg;

  localparam int unsigned DtW    = 20;
  localparam int unsigned AngW   = 16;
  localparam int unsigned YawW   = 16;
  localparam int unsigned CueW   = 2;
  localparam int unsigned ThrW   = 15;
  localparam int unsigned TauW   = 24;
  localparam int unsigned FracW  = 16;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  typedef logic signed [CueW-1:0] cue_t;

  localparam cue_t CUE_NONE  = 2'sb00;
  localparam cue_t CUE_RIGHT = 2'sb01;
  localparam cue_t CUE_LEFT  = 2'sb11;

  localparam logic [1:0] REG_THR = 2'd0;
  localparam logic [1:0] REG_HYS = 2'd1;
  localparam logic [1:0] REG_TAU = 2'd2;

endpackage

// File: src/ysc_if.sv
// valid/ready channels for sample requests and cue results
// depends on ysc_pkg for field widths
interface ysc_in_if import ysc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic                   sample_valid;
  logic [DtW-1:0]         step_time_us;
  logic signed [YawW-1:0] yaw_rate;
  logic signed [AngW-1:0] attack_angle;
  logic signed [AngW-1:0] stall_angle;

  modport source (
    output valid, func, sample_valid, step_time_us, yaw_rate, attack_angle, stall_angle,
    input  ready
  );
  modport sink (
    input  valid, func, sample_valid, step_time_us, yaw_rate, attack_angle, stall_angle,
    output ready
  );
endinterface

interface ysc_out_if import ysc_pkg::*; ();
  logic valid;
  logic ready;
  cue_t rudder_cue;

  modport source (output valid, rudder_cue, input ready);
  modport sink (input valid, rudder_cue, output ready);
endinterface

// File: src/yaw_spin_cue_detector_top.sv
// yaw spin cue detector: request capture, serial alpha divider, serial filter
// multiplier, cue state; depends on ysc_pkg and the channels in ysc_if.sv
//
// One sample request is taken at a time. A filter update runs from accept
// through the states S_DIV, a restoring divider for alpha = dt/(tau+dt),
// S_MUL, a shift-add multiplier for alpha times the yaw error, S_UPD, which
// updates the filter, and S_FIN, which evaluates the cue gates. Clear
// requests, invalid or zero-step samples and the seeding sample go straight
// to S_FIN. The next request is accepted the cycle after the result is loaded
// into the output register; a stalled output holds the result stage.
module yaw_spin_cue_detector_top import ysc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  ysc_in_if.sink           in_i,
  ysc_out_if.source        out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [1:0] K_CLEAR = 2'd0;
  localparam logic [1:0] K_HOLD  = 2'd1;
  localparam logic [1:0] K_SEED  = 2'd2;
  localparam logic [1:0] K_RUN   = 2'd3;

  localparam int unsigned DenW  = TauW + 1;
  localparam int unsigned DiffW = YawW + FracW + 1;
  localparam int unsigned ProdW = DiffW + FracW;
  localparam int unsigned MagW  = 2 * FracW + 1;

  // configuration
  logic [ThrW-1:0] thr_q, hys_q;
  logic [TauW-1:0] tau_q;
  logic            cfg_wr;

  // detector state
  logic signed [31:0] fy_q;
  logic               active_q, seeded_q, armed_q;
  cue_t               dir_q;

  // sequencer and datapath
  logic [2:0]             state_q;
  logic [1:0]             kind_q;
  logic [3:0]             cnt_q;
  logic signed [YawW-1:0] yaw_q;
  logic signed [AngW-1:0] aoa_q, stall_q;
  logic [DenW-1:0]        den_q, rem_q;
  logic [FracW-1:0]       quo_q;
  logic [ProdW-1:0]       mcand_q, acc_q;
  logic                   out_valid_q;
  cue_t                   out_cue_q;

  logic                   accept, out_free;
  logic [DenW:0]          rem2;
  logic                   div_ge;
  logic [DiffW-1:0]       diff;
  logic [MagW-1:0]        fy_ext, fmag, thr_ext, lim_ext;
  logic [YawW:0]          yaw_ext, ymag;
  logic signed [ThrW:0]   lim;
  logic                   stalled, raw_fast, filt_fast, cleared;
  logic                   run_active, run_armed;
  cue_t                   run_dir;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_THR: prdata = {{(DataW-ThrW){1'b0}}, thr_q};
      REG_HYS: prdata = {{(DataW-ThrW){1'b0}}, hys_q};
      REG_TAU: prdata = {{(DataW-TauW){1'b0}}, tau_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(480);
      hys_q <= ThrW'(160);
      tau_q <= TauW'(300000);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_THR: if (pwdata[ThrW-1:0] != '0) thr_q <= pwdata[ThrW-1:0];
        REG_HYS: if (pwdata[ThrW-1:0] != '0) hys_q <= pwdata[ThrW-1:0];
        REG_TAU: if (pwdata[TauW-1:0] != '0) tau_q <= pwdata[TauW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign accept           = in_i.valid && in_i.ready;
  assign out_free         = !out_valid_q || out_o.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.rudder_cue = out_cue_q;

  // one restoring divide step per cycle
  assign rem2   = {rem_q, 1'b0};
  assign div_ge = rem2 >= {1'b0, den_q};

  // yaw error in the filter's fraction scale
  assign diff = {yaw_q[YawW-1], yaw_q, {FracW{1'b0}}} - {fy_q[31], fy_q};

  // cue gates on the updated filter value
  assign fy_ext    = {fy_q[31], fy_q};
  assign fmag      = fy_q[31] ? (MagW'(0) - fy_ext) : fy_ext;
  assign yaw_ext   = {yaw_q[YawW-1], yaw_q};
  assign ymag      = yaw_q[YawW-1] ? ((YawW+1)'(0) - yaw_ext) : yaw_ext;
  assign thr_ext   = {2'b00, thr_q, {FracW{1'b0}}};
  assign lim       = $signed({1'b0, thr_q}) - $signed({1'b0, hys_q});
  assign lim_ext   = {2'b00, lim[ThrW-1:0], {FracW{1'b0}}};
  assign stalled   = aoa_q > stall_q;
  assign raw_fast  = ymag > {2'b00, thr_q};
  assign filt_fast = fmag > thr_ext;
  // a drop limit of zero or below never clears
  assign cleared   = !lim[ThrW] && (lim != '0) && (fmag < lim_ext);

  always_comb begin
    run_active = active_q;
    run_dir    = dir_q;
    run_armed  = armed_q;
    if (!active_q && armed_q && stalled && raw_fast && filt_fast) begin
      run_active = 1'b1;
      run_dir    = (fy_q > 0) ? CUE_LEFT : CUE_RIGHT;
      run_armed  = 1'b0;
    end
    if (run_active && cleared) begin
      run_active = 1'b0;
      run_dir    = CUE_NONE;
    end
    if (!stalled) begin
      run_active = 1'b0;
      run_dir    = CUE_NONE;
      run_armed  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_CLEAR;
      cnt_q       <= '0;
      fy_q        <= '0;
      active_q    <= 1'b0;
      dir_q       <= CUE_NONE;
      seeded_q    <= 1'b0;
      armed_q     <= 1'b1;
      out_valid_q <= 1'b0;
      out_cue_q   <= CUE_NONE;
    end else begin
      // the result stage reloads the output register itself
      if (out_o.ready && state_q != S_FIN) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            if (in_i.func) begin
              kind_q  <= K_CLEAR;
              state_q <= S_FIN;
            end else if (!in_i.sample_valid || in_i.step_time_us == '0) begin
              kind_q  <= K_HOLD;
              state_q <= S_FIN;
            end else if (!seeded_q) begin
              kind_q  <= K_SEED;
              state_q <= S_FIN;
            end else begin
              kind_q  <= K_RUN;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'hF) state_q <= S_MUL;
        end
        S_MUL: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'hF) state_q <= S_UPD;
        end
        S_UPD: begin
          fy_q    <= fy_q + $signed(acc_q[FracW+31:FracW]);
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            case (kind_q)
              K_CLEAR: begin
                fy_q      <= '0;
                active_q  <= 1'b0;
                dir_q     <= CUE_NONE;
                seeded_q  <= 1'b0;
                armed_q   <= 1'b1;
                out_cue_q <= CUE_NONE;
              end
              K_HOLD: out_cue_q <= active_q ? dir_q : CUE_NONE;
              K_SEED: begin
                fy_q      <= {yaw_q, {FracW{1'b0}}};
                seeded_q  <= 1'b1;
                out_cue_q <= CUE_NONE;
              end
              K_RUN: begin
                active_q  <= run_active;
                dir_q     <= run_dir;
                armed_q   <= run_armed;
                out_cue_q <= run_active ? run_dir : CUE_NONE;
              end
              default: out_cue_q <= CUE_NONE;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          yaw_q   <= in_i.yaw_rate;
          aoa_q   <= in_i.attack_angle;
          stall_q <= in_i.stall_angle;
          den_q   <= {1'b0, tau_q} + DenW'(in_i.step_time_us);
          rem_q   <= DenW'(in_i.step_time_us);
          quo_q   <= '0;
        end
      end
      S_DIV: begin
        rem_q <= div_ge ? DenW'(rem2 - {1'b0, den_q}) : rem2[DenW-1:0];
        quo_q <= {quo_q[FracW-2:0], div_ge};
        if (cnt_q == 4'hF) begin
          mcand_q <= {{(ProdW-DiffW){diff[DiffW-1]}}, diff};
          acc_q   <= '0;
        end
      end
      S_MUL: begin
        // alpha bits taken lsb first against a left-shifting error
        if (quo_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q <= {mcand_q[ProdW-2:0], 1'b0};
        quo_q   <= {1'b0, quo_q[FracW-1:1]};
      end
      default: ;
    endcase
  end

  a_active_has_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (dir_q == CUE_LEFT || dir_q == CUE_RIGHT))
    else $error("active cue without a direction");

  a_idle_no_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (dir_q == CUE_NONE))
    else $error("direction held while cue inactive");

  a_active_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !armed_q)
    else $error("cue active while still armed for entry");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("new request taken before the previous one finished");

  a_run_reaches_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_MUL) |-> (kind_q == K_RUN && seeded_q))
    else $error("filter update running without a seeded filter");

endmodule
